@@ rtl/mshr_pkg.sv @@
// Shared constants, codes and types of the miss status holding register entry.
package mshr_pkg;

	localparam int TARGETS_PER_LIST = 8;
	localparam int TAG_BITS         = 8;
	localparam int IDX_W            = $clog2(TARGETS_PER_LIST);
	localparam int SLOT_W           = IDX_W + 1;
	localparam int MEM_DEPTH        = 2 * (1 << IDX_W);
	localparam int CNT_W            = $clog2(TARGETS_PER_LIST + 1);
	localparam int TOT_W            = CNT_W + 1;

	typedef enum logic [2:0] {
		OP_ALLOC   = 3'd0,
		OP_ADD     = 3'd1,
		OP_SNOOP   = 3'd2,
		OP_ISSUE   = 3'd3,
		OP_POP     = 3'd4,
		OP_FILL    = 3'd5,
		OP_PROMOTE = 3'd6,
		OP_DEALLOC = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		CMD_RD_SHARED = 2'd0,
		CMD_RD_EX     = 2'd1,
		CMD_UPGRADE   = 2'd2,
		CMD_OTHER_EX  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_ILLEGAL = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_sts_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic                from_cpu;
		logic [15:0]         order;
		logic [31:0]         ready;
	} slot_t;

endpackage

@@ rtl/mshr_req_if.sv @@
// Request channel: one operation item for the entry.
interface mshr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [47:0] block_addr;
	logic [7:0]  req_size;
	logic [7:0]  req_id;
	logic [1:0]  req_cmd;
	logic        uncacheable;
	logic [31:0] ready_at;
	logic [15:0] order_num;
	logic [31:0] now_tick;
	logic        express_snoop;
	logic        deferred_snoop;

	modport source (
		output valid, opcode, block_addr, req_size, req_id, req_cmd, uncacheable,
			ready_at, order_num, now_tick, express_snoop, deferred_snoop,
		input ready
	);
	modport sink (
		input valid, opcode, block_addr, req_size, req_id, req_cmd, uncacheable,
			ready_at, order_num, now_tick, express_snoop, deferred_snoop,
		output ready
	);
endinterface

@@ rtl/mshr_rsp_if.sv @@
// Response channel: one result item per operation.
interface mshr_rsp_if;
	logic        valid;
	logic        ready;
	logic        snoop_taken;
	logic        mem_inhibit;
	logic        shared_asserted;
	logic        promoted;
	logic        target_valid;
	logic [7:0]  target_tag;
	logic [1:0]  target_kind;
	logic        target_from_cpu;
	logic [15:0] target_order;
	logic [31:0] entry_ready_time;
	logic [4:0]  target_total;
	logic [1:0]  status;

	modport source (
		output valid, snoop_taken, mem_inhibit, shared_asserted, promoted, target_valid,
			target_tag, target_kind, target_from_cpu, target_order, entry_ready_time,
			target_total, status,
		input ready
	);
	modport sink (
		input valid, snoop_taken, mem_inhibit, shared_asserted, promoted, target_valid,
			target_tag, target_kind, target_from_cpu, target_order, entry_ready_time,
			target_total, status,
		output ready
	);
endinterface

@@ rtl/mshr_ctrl.sv @@
// Sequencing controller: accept, target read, execute.
module mshr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mshr_pkg::ctrl_sts_t sts,
	output mshr_pkg::ctrl_cmd_t cmd
);
	import mshr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_EX   = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_RD;
			S_RD:   state_d = S_EX;
			S_EX:   if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready   = (state_q == S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && req_valid;
	assign cmd.read    = (state_q == S_RD);
	assign cmd.exec    = (state_q == S_EX) && sts.out_free;

	a_capture_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_RD))
		else $error("accepted item did not move on to the target read");

endmodule

@@ rtl/mshr_dp.sv @@
// Entry datapath: entry state, target lists, target memory and result register.
module mshr_dp (
	input  logic                clk,
	input  logic                arst_n,
	mshr_req_if.sink            req,
	mshr_rsp_if.source          rsp,
	input  mshr_pkg::ctrl_cmd_t cmd,
	output mshr_pkg::ctrl_sts_t sts
);
	import mshr_pkg::*;

	// Captured item.
	op_t                 it_op;
	logic [47:0]         it_addr;
	logic [7:0]          it_size;
	logic [TAG_BITS-1:0] it_tag;
	cmd_t                it_cmd;
	logic                it_unc;
	logic [31:0]         it_rdy;
	logic [15:0]         it_ord;
	logic [31:0]         it_now;
	logic                it_exp;
	logic                it_dsn;

	// Entry state.
	logic              busy_q, issued_q, unc_q, inv_q, shr_q, act_q;
	logic [47:0]       addr_q;
	logic [7:0]        size_q;
	logic [31:0]       ready_q;
	logic [15:0]       order_q;
	logic [IDX_W-1:0]  head_q [2];
	logic [CNT_W-1:0]  cnt_q [2];
	logic [1:0]        wex_q, upg_q;
	logic [TOT_W-1:0]  tot_q;
	logic [1:0]        kind_q [MEM_DEPTH];
	slot_t             mem [MEM_DEPTH];
	slot_t             rd_q;
	logic              out_v_q;

	// Next state.
	logic              busy_d, issued_d, unc_d, inv_d, shr_d, act_d;
	logic [47:0]       addr_d;
	logic [7:0]        size_d;
	logic [31:0]       ready_d;
	logic [15:0]       order_d;
	logic [IDX_W-1:0]  head_d [2];
	logic [CNT_W-1:0]  cnt_d [2];
	logic [1:0]        wex_d, upg_d;
	logic [TOT_W-1:0]  tot_d;
	logic [1:0]        kind_d [MEM_DEPTH];

	logic              mem_we;
	logic [SLOT_W-1:0] mem_wa;
	slot_t             mem_wd;
	logic [SLOT_W-1:0] rd_addr;

	logic              r_taken, r_inhibit, r_shared, r_promoted, r_tvalid, r_tcpu;
	logic [TAG_BITS-1:0] r_tag;
	logic [1:0]        r_kind;
	logic [15:0]       r_order;
	status_t           r_status;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [IDX_W+CNT_W-1:0] sum;
		begin
			sum = (IDX_W+CNT_W)'(a) + (IDX_W+CNT_W)'(b);
			if (sum >= (IDX_W+CNT_W)'(TARGETS_PER_LIST))
				sum = sum - (IDX_W+CNT_W)'(TARGETS_PER_LIST);
			return sum[IDX_W-1:0];
		end
	endfunction

	always_comb begin
		logic              act, dfl, excl, add_en, add_l, add_cpu;
		logic [31:0]       add_ready;
		logic [1:0]        rep;
		logic [SLOT_W-1:0] idx;

		act = act_q;
		dfl = ~act_q;
		excl = (it_cmd != CMD_RD_SHARED);
		add_en = 1'b0;
		add_l = act;
		add_cpu = 1'b1;
		add_ready = it_rdy;
		rep = 2'b00;
		idx = '0;

		busy_d = busy_q; issued_d = issued_q; unc_d = unc_q; inv_d = inv_q;
		shr_d = shr_q; act_d = act_q; addr_d = addr_q; size_d = size_q;
		ready_d = ready_q; order_d = order_q; head_d = head_q; cnt_d = cnt_q;
		wex_d = wex_q; upg_d = upg_q; tot_d = tot_q; kind_d = kind_q;
		mem_we = 1'b0; mem_wa = '0; mem_wd = '0;

		r_taken = 1'b0; r_inhibit = 1'b0; r_shared = 1'b0; r_promoted = 1'b0;
		r_tvalid = 1'b0; r_tcpu = 1'b0; r_tag = '0; r_kind = '0; r_order = '0;
		r_status = ST_OK;

		if (!busy_q && it_op != OP_ALLOC && it_op != OP_DEALLOC) begin
			r_status = ST_ILLEGAL;
		end else begin
			unique case (it_op)
				OP_ALLOC: begin
					if (busy_q) begin
						r_status = ST_ILLEGAL;
					end else begin
						busy_d = 1'b1; issued_d = 1'b0; addr_d = it_addr; size_d = it_size;
						unc_d = it_unc; ready_d = it_rdy; order_d = it_ord;
						inv_d = 1'b0; shr_d = 1'b0;
						head_d[0] = '0; head_d[1] = '0; cnt_d[0] = '0; cnt_d[1] = '0;
						wex_d = 2'b00; upg_d = 2'b00; tot_d = '0;
						add_en = 1'b1;
					end
				end
				OP_ADD: begin
					if (issued_q && (cnt_q[dfl] != '0 || inv_q || (!wex_q[act] && excl)))
						add_l = dfl;
					add_en = 1'b1;
				end
				OP_SNOOP: begin
					if (!issued_q || (it_exp && !it_dsn)) begin
						if (excl) rep = 2'b11;
					end else begin
						r_taken = 1'b1;
						if (excl) rep[dfl] = 1'b1;
						if (!inv_q) begin
							if (wex_q[act] || excl) begin
								add_en = 1'b1;
								add_cpu = 1'b0;
								add_ready = it_now;
								if (wex_q[act]) r_inhibit = 1'b1;
								if (excl) inv_d = 1'b1;
							end else begin
								shr_d = 1'b1;
								r_shared = 1'b1;
							end
						end
					end
				end
				OP_ISSUE: issued_d = 1'b1;
				OP_POP: begin
					if (cnt_q[act] == '0) begin
						r_status = ST_ILLEGAL;
					end else begin
						r_tvalid = 1'b1;
						r_tag = rd_q.tag;
						r_kind = kind_q[{act, head_q[act]}];
						r_tcpu = rd_q.from_cpu;
						r_order = rd_q.order;
						head_d[act] = ring_add(head_q[act], CNT_W'(1));
						cnt_d[act] = cnt_q[act] - CNT_W'(1);
						if (tot_q != '0) tot_d = tot_q - TOT_W'(1);
					end
				end
				OP_FILL: r_shared = shr_q;
				OP_PROMOTE: begin
					if (cnt_q[act] != '0) begin
						r_status = ST_ILLEGAL;
					end else if (cnt_q[dfl] != '0) begin
						act_d = dfl;
						head_d[act] = '0; cnt_d[act] = '0; wex_d[act] = 1'b0; upg_d[act] = 1'b0;
						inv_d = 1'b0; shr_d = 1'b0; issued_d = 1'b0;
						order_d = rd_q.order;
						ready_d = (it_now > rd_q.ready) ? it_now : rd_q.ready;
						r_promoted = 1'b1;
					end
				end
				OP_DEALLOC: begin
					if (!busy_q || tot_q != '0) r_status = ST_ILLEGAL;
					busy_d = 1'b0; issued_d = 1'b0; inv_d = 1'b0; shr_d = 1'b0;
					head_d[0] = '0; head_d[1] = '0; cnt_d[0] = '0; cnt_d[1] = '0;
					wex_d = 2'b00; upg_d = 2'b00; tot_d = '0;
				end
				default: r_status = ST_ILLEGAL;
			endcase
		end

		// Upgrade replacement covers the whole half of the store; slots outside
		// the list are rewritten before they are ever read again.
		for (int l = 0; l < 2; l++) begin
			if (rep[l] && upg_d[l]) begin
				for (int i = 0; i < (1 << IDX_W); i++) begin
					idx = {1'(l), IDX_W'(i)};
					if (kind_d[idx] == CMD_UPGRADE) kind_d[idx] = CMD_RD_EX;
				end
				upg_d[l] = 1'b0;
			end
		end

		if (add_en) begin
			if (cnt_d[add_l] >= CNT_W'(TARGETS_PER_LIST)) begin
				r_status = ST_FULL;
			end else begin
				if (add_cpu) begin
					if (excl) wex_d[add_l] = 1'b1;
					if (it_cmd == CMD_UPGRADE) upg_d[add_l] = 1'b1;
				end
				mem_we = 1'b1;
				mem_wa = {add_l, ring_add(head_d[add_l], cnt_d[add_l])};
				mem_wd.tag = it_tag;
				mem_wd.from_cpu = add_cpu;
				mem_wd.order = it_ord;
				mem_wd.ready = add_ready;
				kind_d[mem_wa] = it_cmd;
				cnt_d[add_l] = cnt_d[add_l] + CNT_W'(1);
				tot_d = tot_d + TOT_W'(1);
			end
		end
	end

	assign rd_addr = (it_op == OP_POP) ? {act_q, head_q[act_q]} : {~act_q, head_q[~act_q]};
	assign sts.out_free = !out_v_q || rsp.ready;
	assign rsp.valid = out_v_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			it_op   <= op_t'(req.opcode);
			it_addr <= req.block_addr;
			it_size <= req.req_size;
			it_tag  <= req.req_id[TAG_BITS-1:0];
			it_cmd  <= cmd_t'(req.req_cmd);
			it_unc  <= req.uncacheable;
			it_rdy  <= req.ready_at;
			it_ord  <= req.order_num;
			it_now  <= req.now_tick;
			it_exp  <= req.express_snoop;
			it_dsn  <= req.deferred_snoop;
		end
		if (cmd.read) rd_q <= mem[rd_addr];
		if (cmd.exec && mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.exec) begin
			kind_q <= kind_d;
			rsp.snoop_taken      <= r_taken;
			rsp.mem_inhibit      <= r_inhibit;
			rsp.shared_asserted  <= r_shared;
			rsp.promoted         <= r_promoted;
			rsp.target_valid     <= r_tvalid;
			rsp.target_tag       <= 8'(r_tag);
			rsp.target_kind      <= r_kind;
			rsp.target_from_cpu  <= r_tcpu;
			rsp.target_order     <= r_order;
			rsp.entry_ready_time <= ready_d;
			rsp.target_total     <= 5'(tot_d);
			rsp.status           <= r_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; issued_q <= 1'b0; unc_q <= 1'b0; inv_q <= 1'b0;
			shr_q <= 1'b0; act_q <= 1'b0; addr_q <= '0; size_q <= '0;
			ready_q <= '0; order_q <= '0;
			head_q[0] <= '0; head_q[1] <= '0; cnt_q[0] <= '0; cnt_q[1] <= '0;
			wex_q <= 2'b00; upg_q <= 2'b00; tot_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				busy_q <= busy_d; issued_q <= issued_d; unc_q <= unc_d; inv_q <= inv_d;
				shr_q <= shr_d; act_q <= act_d; addr_q <= addr_d; size_q <= size_d;
				ready_q <= ready_d; order_q <= order_d;
				head_q <= head_d; cnt_q <= cnt_d; wex_q <= wex_d; upg_q <= upg_d;
				tot_q <= tot_d;
			end
			if (cmd.exec) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		tot_q == TOT_W'(cnt_q[0]) + TOT_W'(cnt_q[1]))
		else $error("target total does not match the two list counts");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CNT_W'(TARGETS_PER_LIST) && cnt_q[1] <= CNT_W'(TARGETS_PER_LIST))
		else $error("list count beyond list capacity");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tot_q == '0 && !issued_q))
		else $error("free entry still holds targets or an issue mark");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_v_q)
		else $error("executed item left no result");

endmodule

@@ rtl/mshr_entry_target_manager.sv @@
// Top level of one miss status holding register entry with its target lists.
//
//  channel | dir | handshake     | contents
//  req     | in  | valid/ready   | opcode, address, size, tag, command, ticks, snoop qualifiers
//  rsp     | out | valid/ready   | snoop marks, promote flag, popped target, ready tick, totals
//
// Each item passes through three states: accept, target memory read, execute.
// The next item is accepted in the cycle after execute; the result waits in an output register.
// Execute waits while a previous result is still held and not taken.
// Reset clears the entry, both lists and the controller; target slots are not cleared.
module mshr_entry_target_manager (
	input  logic clk,
	input  logic arst_n,
	mshr_req_if.sink   req,
	mshr_rsp_if.source rsp
);
	import mshr_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      ctrl_ready;

	mshr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctrl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mshr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

	assign req.ready = ctrl_ready;

endmodule

@@ test/tb_mshr_entry_target_manager.sv @@
// Self-checking testbench of the miss status holding register entry with its target lists.
module tb_mshr_entry_target_manager;
	import mshr_pkg::*;

	typedef struct packed {
		op_t         op;
		logic [47:0] addr;
		logic [7:0]  size;
		logic [7:0]  tag;
		cmd_t        cmd;
		logic        unc;
		logic [31:0] ready_at;
		logic [15:0] order;
		logic [31:0] now;
		logic        express;
		logic        dsnoop;
	} op_item_t;

	typedef struct packed {
		logic        snoop_taken;
		logic        mem_inhibit;
		logic        shared_asserted;
		logic        promoted;
		logic        target_valid;
		logic [7:0]  target_tag;
		logic [1:0]  target_kind;
		logic        target_from_cpu;
		logic [15:0] target_order;
		logic [31:0] entry_ready_time;
		logic [4:0]  target_total;
		status_t     status;
	} entry_rsp_t;

	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mshr_req_if req ();
	mshr_rsp_if rsp ();

	mshr_entry_target_manager u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mirror of the entry state, advanced at every accepted item.
	logic        m_busy, m_issued, m_unc, m_inv_pend, m_shr_pend;
	logic [47:0] m_addr;
	logic [7:0]  m_size;
	logic [31:0] m_ready;
	logic [15:0] m_order;
	logic        m_act;
	logic [7:0]  s_tag[16];
	cmd_t        s_kind[16];
	logic        s_cpu[16];
	logic [15:0] s_order[16];
	logic [31:0] s_ready[16];
	logic [2:0]  l_head[2];
	logic [3:0]  l_cnt[2];
	logic        l_wex[2], l_upg[2];
	logic [4:0]  m_total;

	entry_rsp_t expected_rsp_q[$];
	int unsigned n_items, n_checked, n_errors, n_pops, n_promotes, n_full;
	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;
	int  rx_hold_cycles;
	int  rx_idle_left;

	function automatic int slot_of(logic l, int i);
		logic [2:0] pos;
		pos = l_head[l] + 3'(i);
		return int'(l) * 8 + int'(pos);
	endfunction

	function automatic void clear_list(logic l);
		l_head[l] = '0;
		l_cnt[l] = '0;
		l_wex[l] = 1'b0;
		l_upg[l] = 1'b0;
	endfunction

	function automatic bit append_target(logic l, logic [7:0] tag, cmd_t kind, logic cpu,
			logic [15:0] order, logic [31:0] rdy);
		int k;
		if (l_cnt[l] >= 4'(TARGETS_PER_LIST))
			return 1'b0;
		if (cpu) begin
			if (kind != CMD_RD_SHARED)
				l_wex[l] = 1'b1;
			if (kind == CMD_UPGRADE)
				l_upg[l] = 1'b1;
		end
		k = slot_of(l, int'(l_cnt[l]));
		s_tag[k] = tag;
		s_kind[k] = kind;
		s_cpu[k] = cpu;
		s_order[k] = order;
		s_ready[k] = rdy;
		l_cnt[l]++;
		m_total++;
		return 1'b1;
	endfunction

	function automatic void upgrades_to_read_ex(logic l);
		int k;
		if (!l_upg[l])
			return;
		for (int i = 0; i < int'(l_cnt[l]); i++) begin
			k = slot_of(l, i);
			if (s_kind[k] == CMD_UPGRADE)
				s_kind[k] = CMD_RD_EX;
		end
		l_upg[l] = 1'b0;
	endfunction

	function automatic void reset_entry_model();
		m_busy = 0; m_issued = 0; m_unc = 0; m_inv_pend = 0; m_shr_pend = 0;
		m_addr = '0; m_size = '0; m_ready = '0; m_order = '0; m_act = 0;
		clear_list(0);
		clear_list(1);
		m_total = '0;
	endfunction

	function automatic entry_rsp_t predict_entry_rsp(op_item_t it);
		entry_rsp_t r;
		logic act, def, tgt;
		bit excl;
		int k;
		r = '0;
		act = m_act;
		def = ~m_act;
		excl = (it.cmd != CMD_RD_SHARED);
		if (!m_busy && it.op != OP_ALLOC && it.op != OP_DEALLOC) begin
			r.status = ST_ILLEGAL;
		end else begin
			case (it.op)
				OP_ALLOC: begin
					if (m_busy) begin
						r.status = ST_ILLEGAL;
					end else begin
						m_busy = 1; m_issued = 0; m_addr = it.addr; m_size = it.size;
						m_unc = it.unc; m_ready = it.ready_at; m_order = it.order;
						m_inv_pend = 0; m_shr_pend = 0;
						clear_list(0);
						clear_list(1);
						m_total = '0;
						void'(append_target(act, it.tag, it.cmd, 1'b1, it.order, it.ready_at));
					end
				end
				OP_ADD: begin
					tgt = act;
					if (m_issued && (l_cnt[def] != 0 || m_inv_pend || (!l_wex[act] && excl)))
						tgt = def;
					if (!append_target(tgt, it.tag, it.cmd, 1'b1, it.order, it.ready_at))
						r.status = ST_FULL;
				end
				OP_SNOOP: begin
					if (!m_issued || (it.express && !it.dsnoop)) begin
						if (excl) begin
							upgrades_to_read_ex(act);
							upgrades_to_read_ex(def);
						end
					end else begin
						r.snoop_taken = 1;
						if (excl)
							upgrades_to_read_ex(def);
						if (!m_inv_pend) begin
							if (l_wex[act] || excl) begin
								if (!append_target(act, it.tag, it.cmd, 1'b0, it.order, it.now))
									r.status = ST_FULL;
								if (l_wex[act])
									r.mem_inhibit = 1;
								if (excl)
									m_inv_pend = 1;
							end else begin
								m_shr_pend = 1;
								r.shared_asserted = 1;
							end
						end
					end
				end
				OP_ISSUE: m_issued = 1;
				OP_POP: begin
					if (l_cnt[act] == 0) begin
						r.status = ST_ILLEGAL;
					end else begin
						k = slot_of(act, 0);
						r.target_valid = 1;
						r.target_tag = s_tag[k];
						r.target_kind = s_kind[k];
						r.target_from_cpu = s_cpu[k];
						r.target_order = s_order[k];
						l_head[act]++;
						l_cnt[act]--;
						if (m_total != 0)
							m_total--;
					end
				end
				OP_FILL: r.shared_asserted = m_shr_pend;
				OP_PROMOTE: begin
					if (l_cnt[act] != 0) begin
						r.status = ST_ILLEGAL;
					end else if (l_cnt[def] != 0) begin
						m_act = def;
						clear_list(act);
						m_inv_pend = 0; m_shr_pend = 0; m_issued = 0;
						k = slot_of(def, 0);
						m_order = s_order[k];
						m_ready = (it.now > s_ready[k]) ? it.now : s_ready[k];
						r.promoted = 1;
					end
				end
				default: begin
					if (!m_busy || m_total != 0)
						r.status = ST_ILLEGAL;
					m_busy = 0; m_issued = 0; m_inv_pend = 0; m_shr_pend = 0;
					clear_list(0);
					clear_list(1);
					m_total = '0;
				end
			endcase
		end
		r.entry_ready_time = m_ready;
		r.target_total = m_total;
		return r;
	endfunction

	function automatic op_item_t random_item(op_t op);
		op_item_t it;
		it.op = op;
		it.addr = {16'($urandom), $urandom};
		it.size = 8'($urandom);
		it.tag = 8'($urandom);
		it.cmd = cmd_t'($urandom_range(0, 3));
		it.unc = 1'($urandom);
		it.ready_at = $urandom;
		it.order = 16'($urandom);
		it.now = $urandom;
		it.express = 1'($urandom);
		it.dsnoop = 1'($urandom);
		return it;
	endfunction

	task automatic send_item(op_item_t it);
		int gap;
		entry_rsp_t exp_r;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= it.op;
		req.block_addr <= it.addr;
		req.req_size <= it.size;
		req.req_id <= it.tag;
		req.req_cmd <= it.cmd;
		req.uncacheable <= it.unc;
		req.ready_at <= it.ready_at;
		req.order_num <= it.order;
		req.now_tick <= it.now;
		req.express_snoop <= it.express;
		req.deferred_snoop <= it.dsnoop;
		do @(posedge clk); while (!req.ready);
		exp_r = predict_entry_rsp(it);
		expected_rsp_q.insert(expected_rsp_q.size(), exp_r);
		n_items++;
	endtask

	task automatic send_op(op_t op, cmd_t cmd);
		op_item_t it;
		it = random_item(op);
		it.cmd = cmd;
		send_item(it);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Result checker and receiver idling.
	always @(posedge clk) begin
		entry_rsp_t e;
		if (rsp.valid && rsp.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result item with nothing expected");
				n_errors++;
			end else begin
				e = expected_rsp_q.pop_front();
				n_checked++;
				if (e.target_valid) n_pops++;
				if (e.promoted) n_promotes++;
				if (e.status == ST_FULL) n_full++;
				if (rsp.snoop_taken !== e.snoop_taken) begin
					$error("snoop_taken exp %0h got %0h", e.snoop_taken, rsp.snoop_taken);
					n_errors++;
				end
				if (rsp.mem_inhibit !== e.mem_inhibit) begin
					$error("mem_inhibit exp %0h got %0h", e.mem_inhibit, rsp.mem_inhibit);
					n_errors++;
				end
				if (rsp.shared_asserted !== e.shared_asserted) begin
					$error("shared_asserted exp %0h got %0h", e.shared_asserted,
						rsp.shared_asserted);
					n_errors++;
				end
				if (rsp.promoted !== e.promoted) begin
					$error("promoted exp %0h got %0h", e.promoted, rsp.promoted);
					n_errors++;
				end
				if (rsp.target_valid !== e.target_valid) begin
					$error("target_valid exp %0h got %0h", e.target_valid, rsp.target_valid);
					n_errors++;
				end
				if (rsp.target_tag !== e.target_tag) begin
					$error("target_tag exp %0h got %0h", e.target_tag, rsp.target_tag);
					n_errors++;
				end
				if (rsp.target_kind !== e.target_kind) begin
					$error("target_kind exp %0h got %0h", e.target_kind, rsp.target_kind);
					n_errors++;
				end
				if (rsp.target_from_cpu !== e.target_from_cpu) begin
					$error("target_from_cpu exp %0h got %0h", e.target_from_cpu,
						rsp.target_from_cpu);
					n_errors++;
				end
				if (rsp.target_order !== e.target_order) begin
					$error("target_order exp %0h got %0h", e.target_order, rsp.target_order);
					n_errors++;
				end
				if (rsp.entry_ready_time !== e.entry_ready_time) begin
					$error("entry_ready_time exp %0h got %0h", e.entry_ready_time,
						rsp.entry_ready_time);
					n_errors++;
				end
				if (rsp.target_total !== e.target_total) begin
					$error("target_total exp %0h got %0h", e.target_total, rsp.target_total);
					n_errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status exp %0h got %0h", e.status, rsp.status);
					n_errors++;
				end
			end
		end
		if (arst_n) begin
			if (rx_hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (rx_idle_left > 0) begin
				rsp.ready <= 1'b0;
				rx_idle_left--;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				rsp.ready <= 1'b0;
				rx_idle_left = $urandom_range(0, 18);
			end else begin
				rsp.ready <= 1'b1;
			end
		end else begin
			rsp.ready <= 1'b0;
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		int stall;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall = 0;
		else
			stall++;
		if (stall >= STALL_LIMIT) begin
			$display("tb_mshr_entry_target_manager NOT OK");
			$finish;
		end
	end

	task automatic test_directed();
		op_item_t it;
		send_op(OP_POP, CMD_RD_SHARED);      // illegal while not busy
		send_op(OP_DEALLOC, CMD_RD_SHARED);  // dealloc while not busy
		it = random_item(OP_ALLOC);
		it.addr = '1; it.size = '1; it.tag = '1; it.cmd = CMD_UPGRADE;
		it.ready_at = '1; it.order = '1; it.unc = 1;
		send_item(it);
		send_op(OP_ALLOC, CMD_RD_SHARED);    // alloc while busy
		for (int i = 0; i < 8; i++)
			send_op(OP_ADD, cmd_t'(i % 4));    // fills the active list and drops one
		send_op(OP_ISSUE, CMD_RD_SHARED);
		it = random_item(OP_SNOOP);
		it.cmd = CMD_UPGRADE; it.express = 0;
		send_item(it);                        // memory-side upgrade snoop, dropped by the full active list
		send_op(OP_FILL, CMD_RD_SHARED);
		send_op(OP_PROMOTE, CMD_RD_SHARED);  // active list not empty
		send_op(OP_DEALLOC, CMD_RD_SHARED);  // discards targets
		it = random_item(OP_ALLOC);
		it.addr = '0; it.size = '0; it.tag = '0; it.cmd = CMD_RD_SHARED;
		it.ready_at = '0; it.order = '0; it.unc = 0;
		send_item(it);
		send_op(OP_ISSUE, CMD_RD_SHARED);
		it = random_item(OP_SNOOP);
		it.cmd = CMD_RD_SHARED; it.express = 1; it.dsnoop = 1;
		send_item(it);                        // asserts shared
		send_op(OP_ADD, CMD_RD_EX);           // deferred
		send_op(OP_POP, CMD_RD_SHARED);
		send_op(OP_POP, CMD_RD_SHARED);      // empty active list
		send_op(OP_PROMOTE, CMD_RD_SHARED);
		send_op(OP_PROMOTE, CMD_RD_SHARED);  // nonempty active list now
		send_op(OP_POP, CMD_RD_SHARED);
		send_op(OP_PROMOTE, CMD_RD_SHARED);  // empty deferred list
		send_op(OP_DEALLOC, CMD_RD_SHARED);
	endtask

	task automatic send_random(int count);
		int w;
		op_t op;
		for (int n = 0; n < count; n++) begin
			w = $urandom_range(0, 99);
			if (w < 8)
				op = op_t'($urandom_range(0, 7));
			else if (!m_busy)
				op = (w < 90) ? OP_ALLOC : OP_DEALLOC;
			else if (w < 45)
				op = OP_ADD;
			else if (w < 60)
				op = OP_SNOOP;
			else if (w < 66)
				op = OP_ISSUE;
			else if (w < 80)
				op = OP_POP;
			else if (w < 84)
				op = OP_FILL;
			else if (w < 93)
				op = OP_PROMOTE;
			else if (w < 97 || m_total == 0)
				op = OP_DEALLOC;
			else
				op = OP_ALLOC;
			send_item(random_item(op));
		end
	endtask

	task automatic test_random_mix();
		send_random(300);
	endtask

	task automatic test_backpressure();
		rx_hold_cycles = 250;
		send_random(40);
	endtask

	task automatic test_pause_until_drained();
		send_random(60);
		wait_drained();
		send_random(100);
	endtask

	task automatic test_full_rate();
		tx_idle_en = 0;
		rx_idle_en = 0;
		send_random(120);
	endtask

	initial begin
		req.valid = 1'b0;
		req.opcode = OP_ALLOC;
		req.block_addr = '0;
		req.req_size = '0;
		req.req_id = '0;
		req.req_cmd = CMD_RD_SHARED;
		req.uncacheable = 1'b0;
		req.ready_at = '0;
		req.order_num = '0;
		req.now_tick = '0;
		req.express_snoop = 1'b0;
		req.deferred_snoop = 1'b0;
		reset_entry_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_backpressure();
		test_pause_until_drained();
		test_full_rate();
		wait_drained();
		$display("Sent %0d items, checked %0d results: %0d pops, %0d promotes, %0d full drops.",
			n_items, n_checked, n_pops, n_promotes, n_full);
		$display("Covered illegal ops, list overflow, snoop paths, promotion and back-pressure.");
		if (n_errors == 0)
			$display("tb_mshr_entry_target_manager OK");
		else
			$display("tb_mshr_entry_target_manager NOT OK");
		$finish;
	end

endmodule
